// ----- hdl/pctdec_pkg.sv -----
// ----------------------------------------------------------------------------
// pctdec_pkg
// Shared types and constants for the percent decoder.
// ----------------------------------------------------------------------------
package pctdec_pkg;

  // one-hot phase of the escape tracker
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HIGH = 4'b0010,
    PH_LOW  = 4'b0100,
    PH_DROP = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BADCHAR    = 2'd1,
    ST_BADHEX     = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_t;

  localparam logic [7:0] CH_PERCENT = 8'h25;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       out_last;
  } out_item_t;

  // classification of one raw byte
  typedef struct packed {
    logic       is_literal;
    logic       is_percent;
    logic       is_hex;
    logic [3:0] hex_val;
  } byte_class_t;

  // one step of the phase machine
  typedef struct packed {
    logic      emit;
    out_item_t item;
    phase_t    phase;
    logic [3:0] nibble;
  } step_res_t;

endpackage

// ----- hdl/pctdec_class.sv -----
// ----------------------------------------------------------------------------
// pctdec_class
// Character classifier: literal set, percent sign and hex digit value.
// ----------------------------------------------------------------------------
module pctdec_class (
  input  logic                     special_set,
  input  logic [7:0]               byte_i,
  output pctdec_pkg::byte_class_t  cls_o
);

  logic alnum;
  logic url_special;
  logic uri_special;

  always_comb begin
    alnum       = (byte_i inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]});
    // . - ~ _
    url_special = (byte_i inside {8'h2e, 8'h2d, 8'h7e, 8'h5f});
    // / ? : @ & = + $ #
    uri_special = (byte_i inside {8'h2f, 8'h3f, 8'h3a, 8'h40, 8'h26,
                                  8'h3d, 8'h2b, 8'h24, 8'h23});

    cls_o.is_literal = alnum | url_special | (special_set & uri_special);
    cls_o.is_percent = (byte_i == pctdec_pkg::CH_PERCENT);

    cls_o.is_hex  = 1'b1;
    cls_o.hex_val = 4'd0;
    case (byte_i) inside
      [8'h30:8'h39]: begin
        cls_o.hex_val = byte_i[3:0];
      end
      [8'h41:8'h46], [8'h61:8'h66]: begin
        cls_o.hex_val = byte_i[3:0] + 4'd9;
      end
      default: begin
        cls_o.is_hex = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/pctdec_step.sv -----
// ----------------------------------------------------------------------------
// pctdec_step
// Next-state and result logic of the escape tracker for one byte.
// ----------------------------------------------------------------------------
module pctdec_step (
  input  pctdec_pkg::phase_t       phase_i,
  input  logic [3:0]               nibble_i,
  input  pctdec_pkg::in_item_t     item_i,
  input  pctdec_pkg::byte_class_t  cls_i,
  output pctdec_pkg::step_res_t    res_o
);

  logic last;

  always_comb begin
    last = item_i.in_last;

    res_o.emit           = 1'b0;
    res_o.item.out_byte  = 8'd0;
    res_o.item.status    = pctdec_pkg::ST_OK;
    res_o.item.out_last  = last;
    res_o.phase          = phase_i;
    res_o.nibble         = nibble_i;

    case (phase_i)
      pctdec_pkg::PH_IDLE: begin
        if (cls_i.is_percent) begin
          if (last) begin
            res_o.emit        = 1'b1;
            res_o.item.status = pctdec_pkg::ST_INCOMPLETE;
            res_o.phase       = pctdec_pkg::PH_IDLE;
            res_o.nibble      = 4'd0;
          end else begin
            res_o.phase = pctdec_pkg::PH_HIGH;
          end
        end else if (cls_i.is_literal) begin
          res_o.emit          = 1'b1;
          res_o.item.out_byte = item_i.in_byte;
        end else begin
          res_o.emit        = 1'b1;
          res_o.item.status = pctdec_pkg::ST_BADCHAR;
          res_o.phase       = last ? pctdec_pkg::PH_IDLE : pctdec_pkg::PH_DROP;
          res_o.nibble      = 4'd0;
        end
      end
      pctdec_pkg::PH_HIGH: begin
        if (last || !cls_i.is_hex) begin
          // incomplete wins over a bad digit on the last byte
          res_o.emit        = 1'b1;
          res_o.item.status = last ? pctdec_pkg::ST_INCOMPLETE : pctdec_pkg::ST_BADHEX;
          res_o.phase       = last ? pctdec_pkg::PH_IDLE : pctdec_pkg::PH_DROP;
          res_o.nibble      = 4'd0;
        end else begin
          res_o.nibble = cls_i.hex_val;
          res_o.phase  = pctdec_pkg::PH_LOW;
        end
      end
      pctdec_pkg::PH_LOW: begin
        res_o.emit   = 1'b1;
        res_o.nibble = 4'd0;
        if (!cls_i.is_hex) begin
          res_o.item.status = pctdec_pkg::ST_BADHEX;
          res_o.phase       = last ? pctdec_pkg::PH_IDLE : pctdec_pkg::PH_DROP;
        end else begin
          res_o.item.out_byte = {nibble_i, cls_i.hex_val};
          res_o.phase         = pctdec_pkg::PH_IDLE;
        end
      end
      default: begin
        // dropping the rest of a failed string
        if (last) begin
          res_o.phase = pctdec_pkg::PH_IDLE;
        end
      end
    endcase

    if (res_o.item.status != pctdec_pkg::ST_OK) begin
      res_o.item.out_last = 1'b1;
    end
  end

endmodule

// ----- hdl/percent_decoder.sv -----
// ----------------------------------------------------------------------------
// percent_decoder
// Streaming percent-escape decoder, one encoded byte per transfer.
// ----------------------------------------------------------------------------
// path: a byte transferred in passes the input register, then the result
//   register, before its result shows at out_*
// throughput: one byte per cycle while out_ready holds; classifier plus
//   phase machine form the combinational path between the two registers
// reset: synchronous active-low rst_n clears both valid flags, the phase
//   (back to idle), the held high nibble and special_set (url set)
module percent_decoder (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  pctdec_pkg::in_item_t   in_data,

  output logic                   out_valid,
  input  logic                   out_ready,
  output pctdec_pkg::out_item_t  out_data,

  input  logic                   cfg_we,
  input  logic                   cfg_wdata
);

  // input register stage
  logic                  s1_v_r, s1_v_nxt;
  pctdec_pkg::in_item_t  s1_data_r;

  // result register stage
  logic                  out_v_r, out_v_nxt;
  pctdec_pkg::out_item_t out_data_r;

  // escape tracker state and configuration
  pctdec_pkg::phase_t    phase_r, phase_nxt;
  logic [3:0]            nib_r, nib_nxt;
  logic                  special_r;

  pctdec_pkg::byte_class_t cls;
  pctdec_pkg::step_res_t   res;

  logic s1_fire;
  logic in_xfer;

  // the held byte moves on once the result register can take its result;
  // bytes with no result move on as well
  assign s1_fire  = s1_v_r & (~out_v_r | out_ready);
  assign in_ready = ~s1_v_r | s1_fire;
  assign in_xfer  = in_valid & in_ready;

  pctdec_class u_class (
    .special_set (special_r),
    .byte_i      (s1_data_r.in_byte),
    .cls_o       (cls)
  );

  pctdec_step u_step (
    .phase_i  (phase_r),
    .nibble_i (nib_r),
    .item_i   (s1_data_r),
    .cls_i    (cls),
    .res_o    (res)
  );

  always_comb begin
    s1_v_nxt  = s1_v_r;
    out_v_nxt = out_v_r;
    phase_nxt = phase_r;
    nib_nxt   = nib_r;

    if (in_ready) begin
      s1_v_nxt = in_valid;
    end

    // drain on transfer out, refill from the tracker
    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (s1_fire) begin
      out_v_nxt = res.emit;
      phase_nxt = res.phase;
      nib_nxt   = res.nibble;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      phase_r   <= pctdec_pkg::PH_IDLE;
      nib_r     <= 4'd0;
      special_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      phase_r <= phase_nxt;
      nib_r   <= nib_nxt;
      if (cfg_we) begin
        special_r <= cfg_wdata;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (s1_fire && res.emit) begin
      out_data_r <= res.item;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // an error result always closes the string and carries a zero byte
  a_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != pctdec_pkg::ST_OK)
      |-> (out_data.out_last && out_data.out_byte == 8'd0))
    else $error("error result without last flag or with nonzero byte");

  // an error before the end of a string puts the tracker into drop mode
  a_err_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res.emit && res.item.status != pctdec_pkg::ST_OK
      && !s1_data_r.in_last)
      |=> (phase_r == pctdec_pkg::PH_DROP))
    else $error("tracker not dropping after mid-string error");

  // the last byte of a string always leaves the tracker idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_data_r.in_last) |=> (phase_r == pctdec_pkg::PH_IDLE))
    else $error("tracker not idle after last byte");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for percent_decoder: streams encoded strings under both
// special-character sets, predicts each decoded byte or error status, and
// compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 200;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pctdec_pkg::in_item_t  in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pctdec_pkg::out_item_t out_data;
  logic                  cfg_we    = 1'b0;
  logic                  cfg_wdata = 1'b0;

  // hex digit value in either case, -1 for anything else
  function automatic int hex_digit_value(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  // letters, digits and the selected special set pass through
  function automatic bit is_plain_char(logic [7:0] b, bit uri);
    if (b >= "0" && b <= "9") return 1'b1;
    if (b >= "a" && b <= "z") return 1'b1;
    if (b >= "A" && b <= "Z") return 1'b1;
    case (b)
      ".", "-", "~", "_": return 1'b1;
      "/", "?", ":", "@", "&", "=", "+", "$", "#": return uri;
      default: return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // scoreboard: tracks the escape phase and holds the decoded results due
  // --------------------------------------------------------------------------
  class escape_scoreboard;
    pctdec_pkg::phase_t    ph;
    logic [3:0]            high_nib;
    bit                    uri_set;
    pctdec_pkg::out_item_t decoded_due[$];
    int                    errors;

    function new();
      ph       = pctdec_pkg::PH_IDLE;
      high_nib = '0;
      uri_set  = 1'b0;
      errors   = 0;
    endfunction

    function void set_special_set(bit v);
      uri_set = v;
    endfunction

    function int pending();
      return decoded_due.size();
    endfunction

    function void push_result(logic [7:0] b, pctdec_pkg::status_t st, logic last);
      pctdec_pkg::out_item_t r;
      r.out_byte = b;
      r.status   = st;
      r.out_last = last;
      decoded_due.push_back(r);
    endfunction

    // an error always closes the string; drop the tail unless this was last
    function void reject(pctdec_pkg::status_t st, logic last);
      ph       = last ? pctdec_pkg::PH_IDLE : pctdec_pkg::PH_DROP;
      high_nib = '0;
      push_result(8'h00, st, 1'b1);
    endfunction

    function void take_encoded(pctdec_pkg::in_item_t it);
      logic [7:0] b;
      logic       last;
      int         h;
      b    = it.in_byte;
      last = it.in_last;
      h    = hex_digit_value(b);
      case (ph)
        pctdec_pkg::PH_IDLE: begin
          if (b == pctdec_pkg::CH_PERCENT) begin
            if (last) reject(pctdec_pkg::ST_INCOMPLETE, 1'b1);
            else ph = pctdec_pkg::PH_HIGH;
          end else if (is_plain_char(b, uri_set)) begin
            push_result(b, pctdec_pkg::ST_OK, last);
          end else begin
            reject(pctdec_pkg::ST_BADCHAR, last);
          end
        end
        pctdec_pkg::PH_HIGH: begin
          // a cut escape wins over the hex check
          if (last) reject(pctdec_pkg::ST_INCOMPLETE, 1'b1);
          else if (h < 0) reject(pctdec_pkg::ST_BADHEX, 1'b0);
          else begin
            high_nib = h[3:0];
            ph       = pctdec_pkg::PH_LOW;
          end
        end
        pctdec_pkg::PH_LOW: begin
          if (h < 0) reject(pctdec_pkg::ST_BADHEX, last);
          else begin
            push_result({high_nib, h[3:0]}, pctdec_pkg::ST_OK, last);
            ph       = pctdec_pkg::PH_IDLE;
            high_nib = '0;
          end
        end
        default: begin
          if (last) ph = pctdec_pkg::PH_IDLE;
        end
      endcase
    endfunction

    function void check_decoded(pctdec_pkg::out_item_t got);
      pctdec_pkg::out_item_t want;
      if (decoded_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %h status %0d last %0b",
                 $time, got.out_byte, got.status, got.out_last);
        errors++;
        return;
      end
      want = decoded_due.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte mismatch, expected %h, actual %h",
                 $time, want.out_byte, got.out_byte);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.out_last !== want.out_last) begin
        $display("%0t: out_last mismatch, expected %0b, actual %0b",
                 $time, want.out_last, got.out_last);
        errors++;
      end
    endfunction
  endclass

  escape_scoreboard sb;

  percent_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 8 ns clock, rising edges at 4, 12, 20 ...
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // receiver: out_ready follows its own pattern, switching between always
  // ready, coin-flip ready, and mostly ready with occasional stall runs
  // --------------------------------------------------------------------------
  int rx_mode  = 0;
  int rx_left  = 0;
  int rx_stall = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 80);
    end
    rx_left--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          rx_stall = $urandom_range(3, 12);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // every result transfer is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_decoded(out_data);
  end

  // watchdog: too long without any transfer on either channel ends the run
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  int         burst_left = 0;
  int         items_sent = 0;
  logic [7:0] text[$];

  // one byte transfer; called at a falling edge and returns at one
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      // gap before the next burst, sometimes none at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 30);
    end
    in_valid        <= 1'b1;
    in_data.in_byte <= b;
    in_data.in_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_encoded(in_data);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  // sends the queued string with the last flag on its final byte
  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
    text.delete();
  endtask

  // hold off the sender until every predicted result has arrived, then let
  // a pending no-result byte clear the two-stage pipe
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write at the next rising edge, only while the block is idle
  task automatic write_special_set(input bit v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_special_set(v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // string generators
  // --------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
    if (nib < 4'd10) return 8'("0") + 8'(nib);
    return (upper ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] pick_special(bit extra);
    string s;
    s = extra ? "/?:@&=+$#" : ".-~_";
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_literal();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'("a") + 8'($urandom_range(0, 25));
      3, 4:    return 8'("A") + 8'($urandom_range(0, 25));
      5, 6:    return 8'("0") + 8'($urandom_range(0, 9));
      7:       return pick_special(1'b0);
      default: return pick_special(sb.uri_set);
    endcase
  endfunction

  // anything that is not a hex digit, with percent and zero favored
  function automatic logic [7:0] non_hex();
    logic [7:0] v;
    case ($urandom_range(0, 5))
      0: return pctdec_pkg::CH_PERCENT;
      1: return 8'h00;
      default: begin
        do v = 8'($urandom_range(0, 255));
        while (hex_digit_value(v) >= 0);
        return v;
      end
    endcase
  endfunction

  // a literal or a full escape of a random byte, digits in random case
  function automatic void add_token();
    logic [7:0] v;
    if ($urandom_range(0, 2) == 0) begin
      v = 8'($urandom_range(0, 255));
      text.push_back(pctdec_pkg::CH_PERCENT);
      text.push_back(hex_char(v[7:4], 1'($urandom_range(0, 1))));
      text.push_back(hex_char(v[3:0], 1'($urandom_range(0, 1))));
    end else begin
      text.push_back(pick_literal());
    end
  endfunction

  // mostly well-formed strings; the rest carry one fault or are pure noise
  function automatic void add_random_string();
    int kind;
    int n;
    int fault;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      n = $urandom_range(1, 8);
      repeat (n) add_token();
    end else if (kind <= 8) begin
      n = $urandom_range(0, 4);
      repeat (n) add_token();
      fault = $urandom_range(0, 5);
      case (fault)
        0: text.push_back(8'($urandom_range(0, 255)));
        1: begin
          text.push_back(pctdec_pkg::CH_PERCENT);
          text.push_back(non_hex());
        end
        2: begin
          text.push_back(pctdec_pkg::CH_PERCENT);
          text.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
          text.push_back(non_hex());
        end
        // escape cut short by the end of the string
        3: text.push_back(pctdec_pkg::CH_PERCENT);
        4: begin
          text.push_back(pctdec_pkg::CH_PERCENT);
          text.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        end
        // uri-only special, rejected under the url set
        default: text.push_back(pick_special(1'b1));
      endcase
      // trailing bytes after a rejected fault are dropped by the block
      if (fault != 3 && fault != 4) begin
        n = $urandom_range(0, 3);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) add_token();
          else text.push_back(8'($urandom_range(0, 255)));
        end
      end
    end else begin
      n = $urandom_range(1, 5);
      repeat (n) text.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int target;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed strings under the reset (url) set
    // literals plus upper and lower case escapes, 0xff at the top
    text = '{"z", pctdec_pkg::CH_PERCENT, "4", "1", pctdec_pkg::CH_PERCENT, "f", "F", "0"};
    send_text();
    // escape of zero
    text = '{pctdec_pkg::CH_PERCENT, "0", "0"};
    send_text();
    // uri-only char under url set, rest of the string dropped
    text = '{"/", "a", "b"};
    send_text();
    // percent on the last byte
    text = '{pctdec_pkg::CH_PERCENT};
    send_text();
    // high digit on the last byte
    text = '{pctdec_pkg::CH_PERCENT, "A"};
    send_text();
    // percent after a percent, then drop until last
    text = '{pctdec_pkg::CH_PERCENT, pctdec_pkg::CH_PERCENT, "x"};
    send_text();
    // zero byte in literal position, rejected as a bad character
    text = '{8'h00};
    send_text();
    // zero byte as the low digit on the last byte
    text = '{pctdec_pkg::CH_PERCENT, "0", 8'h00};
    send_text();
    // top byte value in literal position, rejected as a bad character
    text = '{8'hFF};
    send_text();

    // random phases, alternating the special set; each config write waits
    // for the block to drain
    for (int phase_idx = 0; phase_idx < 4; phase_idx++) begin
      settle();
      write_special_set(phase_idx % 2 == 0);
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        add_random_string();
        send_text();
      end
    end

    settle();
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/pctdec_pkg.sv
hdl/pctdec_class.sv
hdl/pctdec_step.sv
hdl/percent_decoder.sv
tb/tb_top.sv
